@@ hw/rtl/mrpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meter reading plausibility filter - shared package
// Widths, constants, codes and types used by the filter and its divider.
// ----------------------------------------------------------------------------
package mrpf_pkg;

    // Width of the held meter value (scaled by 10000).
    localparam int VALUE_W = 32;
    // 60000 ms per minute fits in 16 bits, so the scaled change needs 16 more.
    localparam int MS_W = 16;
    localparam int NUM_W = VALUE_W + MS_W;
    // Elapsed time, rate and register widths.
    localparam int EL_W = 32;
    localparam int RATE_W = 32;
    localparam int CNT_W = 32;
    localparam int EPOCH_W = 32;
    localparam int CONF_W = 8;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    localparam logic [EPOCH_W-1:0] EPOCH_FLOOR = EPOCH_W'(1600000000);
    localparam logic [MS_W-1:0] MS_PER_MIN = MS_W'(60000);
    localparam logic [EL_W-1:0] MIN_ELAPSED_MS = EL_W'(3000);
    localparam logic [RATE_W-1:0] RATE_SAT = '1;

    // Input kinds
    localparam logic [1:0] OP_READING = 2'd0;
    localparam logic [1:0] OP_SET = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_MIN_CONF = 2'd0;
    localparam logic [1:0] REG_ALLOW_DEC = 2'd1;
    localparam logic [1:0] REG_MAX_RATE = 2'd2;

    // Reject reasons
    typedef enum logic [2:0] {
        RSN_NONE = 3'd0,
        RSN_RECOG = 3'd1,
        RSN_CONF = 3'd2,
        RSN_DECREASE = 3'd3,
        RSN_RATE = 3'd4
    } reason_t;

    // Status of the divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ hw/rtl/meter_reading_plausibility_filter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meter reading plausibility filter
// Checks recognized meter readings and keeps the accepted meter value.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Contents
// s_*       in         one item: kind in tuser, reading data in tdata
// m_*       out        one result word per item: verdict, state, counters
// cfg_*     in         register writes: min confidence, allow decrease, rate
//
// A word is taken when s_tvalid and s_tready are high at a rising edge.
// Kinds set and clear, failed recognition, low confidence, a forbidden
// decrease, an untimed or first reading go from accept through the evaluate
// state straight to the output state. A reading that is rate checked goes
// on through the divider: the sequencer loads it, the divider produces the
// quotient of the 48-bit scaled change bit by bit and raises its done flag,
// and the verdict is applied. s_tready is high only while the sequencer is
// idle. The result sits in an output register, so the next word can be taken
// while the previous result waits on m_tready; a stalled result holds the
// sequencer before it writes the next one. Reset is asynchronous, active low,
// and clears the held state, counters and configuration; no clearing pass.
//
// The rate check uses the divider alone: with q and r the quotient and
// remainder of the scaled change over the elapsed time, the change exceeds
// the limit exactly when q > limit, or q equals the limit and r is nonzero.
// ----------------------------------------------------------------------------
module meter_reading_plausibility_filter_unit
(
    input  logic          clk,
    input  logic          rst_n,
    // Input stream
    input  logic          s_tvalid,
    output logic          s_tready,
    // tdata from bit 0: recognized_ok, reading[31:0], confidence[7:0],
    // time_ms[31:0], epoch_s[31:0], zero fill to 112 bits
    input  logic [111:0]  s_tdata,
    // tuser: op[1:0]
    input  logic [1:0]    s_tuser,
    // Result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    // tdata from bit 0: accepted, reject_reason[2:0], stored_value[31:0],
    // has_value, value_epoch[31:0], rate_per_min[31:0], reading_count[31:0],
    // reject_count[31:0], save_request, zero fill to 168 bits
    output logic [167:0]  m_tdata,
    // Configuration writes
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_wdata
);
    import mrpf_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration
    logic [CONF_W-1:0]  min_conf_reg;
    logic               allow_dec_reg;
    logic [RATE_W-1:0]  max_rate_reg;

    // Captured item
    logic [1:0]         op_reg;
    logic               ok_reg;
    logic [VALUE_W-1:0] rd_reg;
    logic [CONF_W-1:0]  conf_reg;
    logic [EL_W-1:0]    time_reg;
    logic [EPOCH_W-1:0] epoch_reg;

    // Held state
    logic [VALUE_W-1:0] held_reg;
    logic               present_reg;
    logic [EPOCH_W-1:0] change_epoch_reg;
    logic [EL_W-1:0]    accept_time_reg;
    logic               time_known_reg;
    logic [CNT_W-1:0]   seen_reg;
    logic [CNT_W-1:0]   rejected_reg;
    logic [RATE_W-1:0]  last_rate_reg;
    reason_t            reason_reg;

    // Per-item scratch
    logic [VALUE_W-1:0] mag_reg;
    logic [EL_W-1:0]    el_reg;
    logic               acc_reg;
    logic               save_reg;

    // Output register
    logic               out_valid_reg;
    logic [167:0]       out_data_reg;

    // Datapath signals
    logic               falls;
    logic [VALUE_W-1:0] mag;
    logic [EL_W-1:0]    el_raw;
    logic [EPOCH_W-1:0] epoch_eff;
    logic               div_start;
    logic [NUM_W-1:0]   num;
    div_status_t        div_status;
    logic [NUM_W-1:0]   quo;
    logic [EL_W-1:0]    rem;
    logic               rate_bad;
    logic               out_free;

    assign falls = (rd_reg < held_reg);
    assign mag = falls ? (held_reg - rd_reg) : (rd_reg - held_reg);
    assign el_raw = time_reg - accept_time_reg;
    assign epoch_eff = (epoch_reg > EPOCH_FLOOR) ? epoch_reg : '0;

    // The product is registered inside the divider when it is loaded.
    assign num = NUM_W'(mag_reg) * NUM_W'(MS_PER_MIN);
    assign div_start = (state_reg == S_MUL);

    mrpf_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (num),
        .divisor   (el_reg),
        .status    (div_status),
        .quotient  (quo),
        .remainder (rem)
    );

    assign rate_bad = (max_rate_reg != '0) &&
                      ((quo > NUM_W'(max_rate_reg)) ||
                       ((quo == NUM_W'(max_rate_reg)) && (rem != '0)));

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if ((op_reg == OP_READING) && ok_reg && (conf_reg >= min_conf_reg) &&
                    present_reg && !(falls && !allow_dec_reg) && time_known_reg)
                    state_next = S_MUL;
                else
                    state_next = S_OUT;
            end
            S_MUL:
                state_next = S_DIV;
            S_DIV:
            begin
                if (div_status.done)
                    state_next = S_FIN;
            end
            S_FIN:
                state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_conf_reg <= '0;
            allow_dec_reg <= 1'b0;
            max_rate_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MIN_CONF:  min_conf_reg <= cfg_wdata[CONF_W-1:0];
                REG_ALLOW_DEC: allow_dec_reg <= cfg_wdata[0];
                REG_MAX_RATE:  max_rate_reg <= cfg_wdata[RATE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Input capture
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && s_tvalid)
        begin
            op_reg <= s_tuser;
            ok_reg <= s_tdata[0];
            rd_reg <= VALUE_W'(s_tdata[32:1]);
            conf_reg <= s_tdata[40:33];
            time_reg <= s_tdata[72:41];
            epoch_reg <= s_tdata[104:73];
        end
        if (state_reg == S_EVAL)
        begin
            mag_reg <= mag;
            el_reg <= (el_raw < MIN_ELAPSED_MS) ? MIN_ELAPSED_MS : el_raw;
        end
    end

    // Held state and verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            present_reg <= 1'b0;
            change_epoch_reg <= '0;
            accept_time_reg <= '0;
            time_known_reg <= 1'b0;
            seen_reg <= '0;
            rejected_reg <= '0;
            last_rate_reg <= '0;
            reason_reg <= RSN_NONE;
            acc_reg <= 1'b0;
            save_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_EVAL:
                begin
                    acc_reg <= 1'b0;
                    save_reg <= 1'b0;
                    case (op_reg)
                        OP_SET:
                        begin
                            held_reg <= rd_reg;
                            present_reg <= 1'b1;
                            change_epoch_reg <= epoch_eff;
                            accept_time_reg <= time_reg;
                            time_known_reg <= 1'b1;
                            reason_reg <= RSN_NONE;
                            acc_reg <= 1'b1;
                            save_reg <= 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            held_reg <= '0;
                            present_reg <= 1'b0;
                            change_epoch_reg <= '0;
                            accept_time_reg <= '0;
                            time_known_reg <= 1'b0;
                            reason_reg <= RSN_NONE;
                            acc_reg <= 1'b1;
                            save_reg <= 1'b1;
                        end
                        OP_READING:
                        begin
                            seen_reg <= seen_reg + CNT_W'(1);
                            if (!ok_reg)
                            begin
                                rejected_reg <= rejected_reg + CNT_W'(1);
                                reason_reg <= RSN_RECOG;
                            end
                            else if (conf_reg < min_conf_reg)
                            begin
                                rejected_reg <= rejected_reg + CNT_W'(1);
                                reason_reg <= RSN_CONF;
                            end
                            else if (!present_reg)
                            begin
                                // First reading with nothing held is taken as is.
                                held_reg <= rd_reg;
                                present_reg <= 1'b1;
                                change_epoch_reg <= epoch_eff;
                                accept_time_reg <= time_reg;
                                time_known_reg <= 1'b1;
                                reason_reg <= RSN_NONE;
                                acc_reg <= 1'b1;
                                save_reg <= 1'b1;
                            end
                            else if (falls && !allow_dec_reg)
                            begin
                                rejected_reg <= rejected_reg + CNT_W'(1);
                                reason_reg <= RSN_DECREASE;
                            end
                            else if (!time_known_reg)
                            begin
                                // No timed acceptance yet, so no rate check.
                                held_reg <= rd_reg;
                                accept_time_reg <= time_reg;
                                time_known_reg <= 1'b1;
                                reason_reg <= RSN_NONE;
                                acc_reg <= 1'b1;
                                if (mag != '0)
                                begin
                                    change_epoch_reg <= epoch_eff;
                                    save_reg <= 1'b1;
                                end
                            end
                        end
                        default:
                            ;
                    endcase
                end
                S_FIN:
                begin
                    // The rate is reported even when the reading is refused.
                    last_rate_reg <= (quo > NUM_W'(RATE_SAT)) ? RATE_SAT : RATE_W'(quo);
                    if (rate_bad)
                    begin
                        rejected_reg <= rejected_reg + CNT_W'(1);
                        reason_reg <= RSN_RATE;
                    end
                    else
                    begin
                        held_reg <= rd_reg;
                        accept_time_reg <= time_reg;
                        time_known_reg <= 1'b1;
                        reason_reg <= RSN_NONE;
                        acc_reg <= 1'b1;
                        if (mag_reg != '0)
                        begin
                            change_epoch_reg <= epoch_eff;
                            save_reg <= 1'b1;
                        end
                    end
                end
                default:
                    ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == S_OUT) && out_free)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && out_free)
        begin
            out_data_reg <= {2'b00,
                             save_reg,
                             rejected_reg,
                             seen_reg,
                             last_rate_reg,
                             change_epoch_reg,
                             present_reg,
                             32'(held_reg),
                             reason_reg,
                             acc_reg};
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

endmodule

@@ hw/rtl/mrpf_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meter reading plausibility filter - iterative divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mrpf_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mrpf_pkg::NUM_W-1:0]    dividend,
    input  logic [mrpf_pkg::EL_W-1:0]     divisor,
    output mrpf_pkg::div_status_t         status,
    output logic [mrpf_pkg::NUM_W-1:0]    quotient,
    output logic [mrpf_pkg::EL_W-1:0]     remainder
);
    import mrpf_pkg::*;

    logic [NUM_W-1:0]     quo_reg;
    logic [EL_W-1:0]      rem_reg;
    logic [EL_W-1:0]      dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [EL_W:0]        trial;
    logic [EL_W:0]        diff;
    logic                 fits;

    // One step: bring down the next dividend bit and try the subtraction.
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff = trial - {1'b0, dvs_reg};
    assign fits = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= DIV_CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[EL_W-1:0] : trial[EL_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ hw/rtl/mrpf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meter reading plausibility filter - port checker
// Watches the top level's ports and flags sequences the filter must not show.
// ----------------------------------------------------------------------------
module mrpf_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [167:0]  m_tdata
);
    import mrpf_pkg::*;

    // A taken word keeps the filter busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again right after a word was accepted");

    // A stalled result holds its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

    // An accepted item carries no reject reason.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[3:1] == RSN_NONE)
    else $error("accepted result with a reject reason");

    // A save request only follows an accepted or applied item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[165] |-> m_tdata[0])
    else $error("save request on a refused item");

endmodule

bind meter_reading_plausibility_filter_unit mrpf_checker u_mrpf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
